// ----- sv/quad_attitude_pd_mixer_assert.svh -----
// assertion macros for the attitude pd mixer
`ifndef QUAD_ATTITUDE_PD_MIXER_ASSERT_SVH
`define QUAD_ATTITUDE_PD_MIXER_ASSERT_SVH
// implication checked every clock, held off during reset
`define QAPM_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// next-cycle implication, held off during reset
`define QAPM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`endif

// ----- sv/qapm_pkg.sv -----
// shared types, constants and command codes of the attitude pd mixer
package qapm_pkg;
    localparam int PWM_LOW      = 1000;
    localparam int PWM_HIGH     = 2000;
    localparam int ROLL_CENTER  = 1500;
    localparam int PITCH_CENTER = 1500;
    localparam int YAW_CENTER   = 1500;
    localparam int STICK_MIN    = 1000;
    localparam int STICK_MAX    = 2000;
    localparam int IDLE_PULSE   = 1000;
    localparam int DIV_STEPS    = 34;

    // register indexes
    localparam logic [2:0] REG_KP_ROLL   = 3'd0;
    localparam logic [2:0] REG_KD_ROLL   = 3'd1;
    localparam logic [2:0] REG_KP_PITCH  = 3'd2;
    localparam logic [2:0] REG_KD_PITCH  = 3'd3;
    localparam logic [2:0] REG_KP_YAW    = 3'd4;
    localparam logic [2:0] REG_KD_YAW    = 3'd5;
    localparam logic [2:0] REG_PID_LIMIT = 3'd6;
    localparam logic [2:0] REG_ARM_THR   = 3'd7;

    // datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ERR    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DSTART = 3'd4;
    localparam logic [2:0] OP_DSTEP  = 3'd5;
    localparam logic [2:0] OP_SUM    = 3'd6;
    localparam logic [2:0] OP_MIX    = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;
endpackage

// ----- sv/qapm_ctrl.sv -----
// controller sequencing the three pd axes and the mixer
module qapm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_req,
    input  logic               i_out_free,
    input  qapm_pkg::t_status  i_status,
    output logic               o_busy,
    output logic               o_out_load,
    output qapm_pkg::t_cmd     o_cmd
);
    `include "quad_attitude_pd_mixer_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DST  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_MIX  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        o_cmd.op   = qapm_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_req) begin
                    o_cmd.op = qapm_pkg::OP_LOAD;
                    n_axis   = 2'd0;
                    n_state  = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.op = qapm_pkg::OP_ERR;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = qapm_pkg::OP_MUL;
                n_state  = S_DST;
            end
            S_DST: begin
                o_cmd.op = qapm_pkg::OP_DSTART;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = qapm_pkg::OP_DSTEP;
                if (i_status.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.op = qapm_pkg::OP_SUM;
                if (r_axis == 2'd2) begin
                    n_state = S_MIX;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_ERR;
                end
            end
            S_MIX: begin
                if (i_out_free) begin
                    o_cmd.op   = qapm_pkg::OP_MIX;
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `QAPM_ASSERT_IMP(a_axis_range, i_clk, i_rst_n, 1'b1, r_axis != 2'd3, "axis out of range")
    `QAPM_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, o_out_load, r_state == S_IDLE, "no idle after mix")
    `QAPM_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_out_load, i_out_free, "result load while full")
endmodule

// ----- sv/qapm_datapath.sv -----
// datapath: error, shared multipliers, shared serial divider, clamps and mixer
module qapm_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qapm_pkg::t_cmd     i_cmd,
    input  logic [127:0]       i_frame,
    input  logic [15:0]        i_kp [3],
    input  logic [15:0]        i_kd [3],
    input  logic [10:0]        i_limit,
    input  logic [10:0]        i_arm,
    output qapm_pkg::t_status  o_status,
    output logic [43:0]        o_motors
);
    `include "quad_attitude_pd_mixer_assert.svh"

    logic signed [15:0] r_angle [3];
    logic [10:0]        r_stick [4];
    logic [15:0]        r_dt;
    logic signed [15:0] r_prev [3];
    logic signed [15:0] r_err;
    logic signed [33:0] r_p;
    logic signed [33:0] r_dprod;
    logic [33:0]        r_quo;
    logic [33:0]        r_rem;
    logic [5:0]         r_cnt;
    logic signed [11:0] r_pd [3];
    logic [10:0]        r_out [4];

    // stick clamp
    function automatic logic [10:0] f_clamp_stick(input logic [15:0] v);
        if (v < 16'(qapm_pkg::STICK_MIN)) return 11'(qapm_pkg::STICK_MIN);
        if (v > 16'(qapm_pkg::STICK_MAX)) return 11'(qapm_pkg::STICK_MAX);
        return v[10:0];
    endfunction

    // motor clamp
    function automatic logic [10:0] f_motor(input logic signed [14:0] v);
        if (v > 15'(qapm_pkg::PWM_HIGH)) return 11'(qapm_pkg::PWM_HIGH);
        if (v < 15'(qapm_pkg::PWM_LOW)) return 11'(qapm_pkg::PWM_LOW);
        return v[10:0];
    endfunction

    logic [1:0]         w_ax;
    logic signed [17:0] w_err_full;
    logic signed [15:0] w_err_sat;
    logic signed [16:0] w_diff;
    logic [33:0]        w_dmag;
    logic [24:0]        w_divisor;
    logic [34:0]        w_trial;
    logic signed [35:0] w_sum;
    logic signed [11:0] w_lim;
    logic signed [14:0] w_thr;
    logic signed [14:0] w_m [4];
    logic signed [11:0] w_center;

    assign w_ax = i_cmd.axis;

    // error with saturation
    always_comb begin
        w_center = (w_ax == 2'd0) ? 12'(qapm_pkg::ROLL_CENTER) :
                   ((w_ax == 2'd1) ? 12'(qapm_pkg::PITCH_CENTER) :
                                     12'(qapm_pkg::YAW_CENTER));
        w_err_full = 18'($signed({1'b0, r_stick[w_ax == 2'd2 ? 2'd3 :
                     (w_ax == 2'd1 ? 2'd1 : 2'd0)]}))
                     - 18'(w_center) - 18'(r_angle[w_ax]);
        if (w_err_full > 18'sd32767) w_err_sat = 16'sh7fff;
        else if (w_err_full < -18'sd32768) w_err_sat = 16'sh8000;
        else w_err_sat = w_err_full[15:0];
    end

    assign w_diff    = 17'(r_err) - 17'(r_prev[w_ax]);
    assign w_dmag    = r_dprod[33] ? 34'(-r_dprod) : 34'(r_dprod);
    assign w_divisor = {r_dt, 8'd0, 1'b0} >> 1;
    assign w_trial   = {r_rem[32:0], r_quo[33]} - 35'(w_divisor);

    // axis sum and limit; p truncates toward zero
    always_comb begin
        logic signed [33:0] p_t;
        logic signed [33:0] d_t;
        p_t = (r_p < 0) ? -((-r_p) >>> 8) : (r_p >>> 8);
        d_t = (r_dt == 16'd0) ? 34'sd0 :
              (r_dprod[33] ? -$signed(r_quo) : $signed(r_quo));
        w_sum = 36'(p_t) + 36'(d_t);
        w_lim = 12'($signed({1'b0, i_limit}));
    end

    // mixing
    always_comb begin
        w_thr  = 15'($signed({1'b0, r_stick[2]}));
        w_m[0] = w_thr + 15'(r_pd[1]) + 15'(r_pd[0]) + 15'(r_pd[2]);
        w_m[1] = w_thr + 15'(r_pd[1]) - 15'(r_pd[0]) - 15'(r_pd[2]);
        w_m[2] = w_thr - 15'(r_pd[1]) + 15'(r_pd[0]) - 15'(r_pd[2]);
        w_m[3] = w_thr - 15'(r_pd[1]) - 15'(r_pd[0]) + 15'(r_pd[2]);
    end

    // operation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            r_prev[2] <= '0;
            r_cnt     <= '0;
        end else begin
            case (i_cmd.op)
                qapm_pkg::OP_LOAD: begin
                    r_angle[0] <= i_frame[15:0];
                    r_angle[1] <= i_frame[31:16];
                    r_angle[2] <= i_frame[47:32];
                    r_stick[0] <= f_clamp_stick(i_frame[63:48]);
                    r_stick[1] <= f_clamp_stick(i_frame[79:64]);
                    r_stick[2] <= f_clamp_stick(i_frame[95:80]);
                    r_stick[3] <= f_clamp_stick(i_frame[111:96]);
                    r_dt       <= i_frame[127:112];
                end
                qapm_pkg::OP_ERR: r_err <= w_err_sat;
                qapm_pkg::OP_MUL: begin
                    r_p     <= 34'($signed({1'b0, i_kp[w_ax]}) * r_err);
                    r_dprod <= 34'($signed({1'b0, i_kd[w_ax]}) * w_diff);
                    r_prev[w_ax] <= r_err;
                end
                qapm_pkg::OP_DSTART: begin
                    r_quo <= w_dmag;
                    r_rem <= '0;
                    r_cnt <= 6'(qapm_pkg::DIV_STEPS);
                end
                qapm_pkg::OP_DSTEP: begin
                    // one restoring division bit per cycle
                    if (r_cnt != 6'd0) begin
                        r_cnt <= r_cnt - 6'd1;
                        if (!w_trial[34]) begin
                            r_rem <= w_trial[33:0];
                            r_quo <= {r_quo[32:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[32:0], r_quo[33]};
                            r_quo <= {r_quo[32:0], 1'b0};
                        end
                    end
                end
                qapm_pkg::OP_SUM: begin
                    if (w_sum > 36'(w_lim)) r_pd[w_ax] <= w_lim;
                    else if (w_sum < -36'(w_lim)) r_pd[w_ax] <= -w_lim;
                    else r_pd[w_ax] <= w_sum[11:0];
                end
                qapm_pkg::OP_MIX: begin
                    if (r_stick[2] <= i_arm) begin
                        r_out[0] <= 11'(qapm_pkg::IDLE_PULSE);
                        r_out[1] <= 11'(qapm_pkg::IDLE_PULSE);
                        r_out[2] <= 11'(qapm_pkg::IDLE_PULSE);
                        r_out[3] <= 11'(qapm_pkg::IDLE_PULSE);
                    end else begin
                        r_out[0] <= f_motor(w_m[0]);
                        r_out[1] <= f_motor(w_m[1]);
                        r_out[2] <= f_motor(w_m[2]);
                        r_out[3] <= f_motor(w_m[3]);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status.div_done = (i_cmd.op == qapm_pkg::OP_DSTEP) && (r_cnt == 6'd1);
    assign o_motors = {f_motor(15'(r_out[3])), f_motor(15'(r_out[2])),
                       f_motor(15'(r_out[1])), f_motor(15'(r_out[0]))};

    `QAPM_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, i_cmd.op == qapm_pkg::OP_DSTART, r_cnt == 6'(qapm_pkg::DIV_STEPS), "divider not started")
endmodule

// ----- sv/quad_attitude_pd_mixer.sv -----
// Attitude PD controller with X-mode motor mixer. One frame in, one set of four motor pulses
// out. Each frame runs these steps from acceptance to result: per axis the error, the 17x16
// proportional and 17x17 derivative products, the shared one-bit-per-cycle divider that
// forms the derivative term, and the sum and clamp; then a mix step writes the motor
// pulses and the output register loads them. The serial divider sets the rate: a new frame
// is taken only after the previous one is mixed, later when a held result stalls the mix.
// The result waits in an output register while the next frame is taken. Gains are written
// through the plain write port only while idle: a user rule the block does not enforce.
module quad_attitude_pd_mixer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, roll_stick, pitch_stick, throttle_stick,
    // yaw_stick, elapsed_us
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // motor1_pulse, motor2_pulse, motor3_pulse, motor4_pulse, zero pad
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    logic [15:0] r_kp [3];
    logic [15:0] r_kd [3];
    logic [10:0] r_limit, r_arm;
    logic        r_ovalid;
    logic [43:0] r_odata;
    logic [43:0] w_motors;
    logic        w_busy, w_load;
    qapm_pkg::t_cmd    w_cmd;
    qapm_pkg::t_status w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp[0] <= '0; r_kp[1] <= '0; r_kp[2] <= '0;
            r_kd[0] <= '0; r_kd[1] <= '0; r_kd[2] <= '0;
            r_limit <= 11'd800;
            r_arm   <= 11'd1050;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qapm_pkg::REG_KP_ROLL:   r_kp[0] <= i_cfg_data;
                qapm_pkg::REG_KD_ROLL:   r_kd[0] <= i_cfg_data;
                qapm_pkg::REG_KP_PITCH:  r_kp[1] <= i_cfg_data;
                qapm_pkg::REG_KD_PITCH:  r_kd[1] <= i_cfg_data;
                qapm_pkg::REG_KP_YAW:    r_kp[2] <= i_cfg_data;
                qapm_pkg::REG_KD_YAW:    r_kd[2] <= i_cfg_data;
                qapm_pkg::REG_PID_LIMIT: r_limit <= i_cfg_data[10:0];
                qapm_pkg::REG_ARM_THR:   r_arm   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_busy;

    qapm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_req   (s_axis_tvalid),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_status   (w_status),
        .o_busy     (w_busy),
        .o_out_load (w_load),
        .o_cmd      (w_cmd)
    );

    qapm_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_frame  (s_axis_tdata),
        .i_kp     (r_kp),
        .i_kd     (r_kd),
        .i_limit  (r_limit),
        .i_arm    (r_arm),
        .o_status (w_status),
        .o_motors (w_motors)
    );

    // output register; the mix command writes r_out, then r_pend loads the pulses into r_odata
    logic r_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_pend <= w_load;
            if (r_pend) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_odata <= w_motors;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_odata};
endmodule
